[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks clocked on clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is off while reset is asserted
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cocd_pkg.sv]
// ----------------------------------------------------------------------------
// cocd_pkg
// types, codes and arithmetic helpers of the CAN output command decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cocd_pkg;

  localparam int CHANNELS = 8;
  localparam int ROWS     = CHANNELS / 2;
  localparam int ROW_W    = $clog2(ROWS);

  // configuration register indexes
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_BASE = 2'd1;
  localparam logic [1:0] REG_DFLT = 2'd2;

  // protocol modes (all others select the native layout)
  localparam logic [3:0] MODE_BANK_A  = 4'd1;
  localparam logic [3:0] MODE_BANK_B  = 4'd2;
  localparam logic [3:0] MODE_BANK_AB = 4'd3;
  localparam logic [3:0] MODE_MUX_A   = 4'd4;
  localparam logic [3:0] MODE_MUX_B   = 4'd5;

  // fixed identifiers
  localparam logic [10:0] ID_MUX_CTL = 11'h6A8;
  localparam logic [10:0] ID_MUX_CFG = 11'h6A9;
  localparam logic [10:0] ID_BANK_LO = 11'h2D0;
  localparam logic [10:0] ID_BANK_HI = 11'h2D2;

  localparam logic [2:0] MUX_TAG = 3'd2;

  localparam logic [13:0] FREQ_MIN   = 14'd50;
  localparam logic [13:0] FREQ_MAX   = 14'd10000;
  localparam logic [15:0] BANK_FREQ  = 16'd300;
  localparam logic [13:0] DFLT_RESET = 14'd1000;
  localparam logic [9:0]  MUX_DUTY_MAX = 10'd1000;

  localparam logic [7:0] BANK_RAW_SAT = 8'd250;
  localparam logic [7:0] BANK_SAFE    = 8'h10;
  localparam logic [7:0] BANK_ACTLOW  = 8'h20;

  // reciprocals: floor(x/1000) and floor(x/249) by multiply and shift
  localparam logic [18:0] MUX_RECIP  = 19'd268436;
  localparam logic [16:0] BANK_RECIP = 17'd67379;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PULLUP,
    KIND_MUXCFG,
    KIND_MUXCTL,
    KIND_BANK,
    KIND_NATIVE
  } kind_t;

  // one memory row holds an even/odd channel pair
  typedef struct packed {
    logic [15:0] freq1;
    logic [7:0]  duty1;
    logic [15:0] freq0;
    logic [7:0]  duty0;
  } pair_t;

  // decoded frame, handed from the decode stage to the update stage
  typedef struct packed {
    kind_t            kind;
    logic [ROW_W-1:0] row;
    logic             half;
    logic [7:0]       duty0;
    logic [7:0]       duty1;
    logic [13:0]      freq0;
    logic [13:0]      freq1;
    logic [17:0]      mux_x;
    logic [7:0]       fmask;
    logic [7:0]       fsafe;
    logic [7:0]       fact;
    logic [7:0]       pull;
  } dec_t;

  // native frequency: zero takes the default, then clamp
  function automatic logic [13:0] nat_freq(input logic [15:0] f, input logic [13:0] dflt);
    logic [15:0] v;
    v = (f == 16'd0) ? {2'b00, dflt} : f;
    if (v < {2'b00, FREQ_MIN}) v = {2'b00, FREQ_MIN};
    if (v > {2'b00, FREQ_MAX}) v = {2'b00, FREQ_MAX};
    return v[13:0];
  endfunction

  // (x) / 1000 where x = d*255 + 500, d <= 1000
  function automatic logic [7:0] mux_duty(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(MUX_RECIP);
    return p[35:28];
  endfunction

  // raw 0..249 scaled to 0..255 with rounding
  function automatic logic [7:0] bank_duty(input logic [7:0] r);
    logic [15:0] x;
    logic [32:0] p;
    x = 16'(r) * 16'd255 + 16'd124;
    p = 33'(x) * 33'(BANK_RECIP);
    if (r == 8'd0) return 8'd0;
    if (r >= BANK_RAW_SAT) return 8'd255;
    return p[31:24];
  endfunction

endpackage

`default_nettype wire

[rtl/can_output_command_decoder.sv]
// ----------------------------------------------------------------------------
// can_output_command_decoder
// decodes received CAN frames into PWM channel and mask updates
// ----------------------------------------------------------------------------
// Takes one frame per clock while the result output is not stalled; each frame
// passes through the decode stage register and then the output register before
// its result is offered. Channel duty and frequency live in a 4-row pair
// memory (one row per even/odd channel pair) with a registered read: the
// decode stage decodes the frame and reads the row, the update stage merges
// and writes it back and loads the output register. A frame that touches the
// row written in the same cycle gets the new row forwarded. Masks live in
// flip-flops. Configuration is to be written only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module can_output_command_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data,
  // frame input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [10:0] in_frame_id,
  input  wire logic [3:0]  in_frame_length,
  input  wire logic [7:0]  in_byte0,
  input  wire logic [7:0]  in_byte1,
  input  wire logic [7:0]  in_byte2,
  input  wire logic [7:0]  in_byte3,
  input  wire logic [7:0]  in_byte4,
  input  wire logic [7:0]  in_byte5,
  input  wire logic [7:0]  in_byte6,
  input  wire logic [7:0]  in_byte7,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic [1:0]       out_update_count,
  output logic             out_mask_changed,
  output logic             out_pullup_changed,
  output logic [7:0]       out_safe_mask,
  output logic [7:0]       out_active_mask,
  output logic [7:0]       out_pullup_mask,
  output logic [2:0]       out_first_channel,
  output logic [7:0]       out_first_duty,
  output logic [15:0]      out_first_freq,
  output logic [7:0]       out_second_duty,
  output logic [15:0]      out_second_freq
);
  import cocd_pkg::*;

  // configuration registers
  logic [3:0]  mode_r;
  logic [10:0] base_r;
  logic [13:0] dflt_r;

  // pipeline and state
  dec_t        dec;
  dec_t        s1_r;
  logic        s1_valid_r;
  logic        s1_adv;
  logic        in_fire;
  pair_t       mem [ROWS];
  logic [ROWS-1:0] row_valid_r;
  pair_t       rd_raw_r;
  pair_t       fwd_data_r;
  logic        fwd_hit_r;
  logic        row_ok_r;
  pair_t       old_row;
  pair_t       new_row;
  logic        wr_en;
  logic [7:0]  safe_r, act_r, pull_r;
  logic [7:0]  safe_nxt, act_nxt, pull_nxt;
  logic [7:0]  mux_q, bank_q0, bank_q1;
  logic [1:0]  cnt;

  // output register
  logic        out_valid_r;
  logic        acc_r;
  logic [1:0]  cnt_r;
  logic        mchg_r, pchg_r;
  logic [7:0]  safe_o_r, act_o_r, pull_o_r;
  logic [2:0]  first_ch_r;
  logic [7:0]  first_duty_r, second_duty_r;
  logic [15:0] first_freq_r, second_freq_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 4'd0;
      base_r <= 11'd0;
      dflt_r <= DFLT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode_r <= cfg_data[3:0];
        REG_BASE: base_r <= cfg_data[10:0];
        REG_DFLT: dflt_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // frame decode
  always_comb begin
    logic        mux_ok;
    logic [15:0] d16, p16;
    logic [9:0]  dsat;
    logic [11:0] id12, base12;
    logic        bank_hit;
    logic [1:0]  bank_row;
    logic [10:0] shift;
    logic [1:0]  k;
    logic [2:0]  ch;

    dec      = '0;
    dec.kind = KIND_NONE;
    mux_ok   = (in_byte0[7:5] == MUX_TAG) && (in_byte0[3:2] == 2'b00);
    d16      = {in_byte1, in_byte2};
    p16      = {in_byte3, in_byte4};
    dsat     = (d16 > 16'(MUX_DUTY_MAX)) ? MUX_DUTY_MAX : d16[9:0];
    id12     = {1'b0, in_frame_id};
    base12   = {1'b0, base_r};
    shift    = (mode_r == MODE_BANK_B) ? 11'd1 : 11'd0;
    bank_hit = 1'b1;
    bank_row = 2'd0;
    k        = 2'(id12 - base12);
    ch       = {mode_r == MODE_MUX_B, in_byte0[1:0]};

    if (mode_r == MODE_MUX_A || mode_r == MODE_MUX_B) begin
      // mux layout
      if (in_frame_id == ID_MUX_CTL && in_frame_length >= 4'd5 && mux_ok) begin
        dec.kind  = KIND_MUXCTL;
        dec.row   = ch[2:1];
        dec.half  = ch[0];
        dec.mux_x = 18'(dsat) * 18'd255 + 18'd500;
        if (p16 == 16'd0) dec.freq0 = dflt_r;
        else if (p16[15:2] == 14'd0) dec.freq0 = 14'd1;
        else dec.freq0 = p16[15:2];
      end else if (in_frame_id == ID_MUX_CFG && in_frame_length >= 4'd2 && mux_ok) begin
        dec.kind  = KIND_MUXCFG;
        dec.fmask = 8'd1 << ch;
        dec.fsafe = (in_byte1[2] ^ in_byte1[1]) ? dec.fmask : 8'd0;
        dec.fact  = in_byte1[0] ? dec.fmask : 8'd0;
      end
    end else if (mode_r == MODE_BANK_A || mode_r == MODE_BANK_B ||
                 mode_r == MODE_BANK_AB) begin
      // bank layout
      if (in_frame_id == ID_BANK_LO + shift) bank_row = 2'd0;
      else if (in_frame_id == ID_BANK_HI + shift) bank_row = 2'd1;
      else if (mode_r == MODE_BANK_AB && in_frame_id == ID_BANK_LO + 11'd1) bank_row = 2'd2;
      else if (mode_r == MODE_BANK_AB && in_frame_id == ID_BANK_HI + 11'd1) bank_row = 2'd3;
      else bank_hit = 1'b0;
      if (bank_hit && in_frame_length >= 4'd6) begin
        dec.kind  = KIND_BANK;
        dec.row   = bank_row;
        dec.duty0 = in_byte0;
        dec.duty1 = in_byte4;
        dec.fmask = 8'b11 << {bank_row, 1'b0};
        dec.fsafe = {6'd0, |(in_byte5 & BANK_SAFE), |(in_byte1 & BANK_SAFE)}
                    << {bank_row, 1'b0};
        dec.fact  = {6'd0, ~|(in_byte5 & BANK_ACTLOW), ~|(in_byte1 & BANK_ACTLOW)}
                    << {bank_row, 1'b0};
      end
    end else begin
      // native layout
      if (id12 == base12 + 12'd4) begin
        if (in_frame_length >= 4'd1) begin
          dec.kind = KIND_PULLUP;
          dec.pull = in_byte0;
        end
      end else if (id12 >= base12 && id12 <= base12 + 12'd3 && in_frame_length >= 4'd8) begin
        dec.kind  = KIND_NATIVE;
        dec.row   = k;
        dec.freq0 = nat_freq({in_byte1, in_byte0}, dflt_r);
        dec.freq1 = nat_freq({in_byte5, in_byte4}, dflt_r);
        dec.duty0 = in_byte2;
        dec.duty1 = in_byte6;
        dec.fmask = 8'b11 << {k, 1'b0};
        dec.fsafe = {6'd0, in_byte7[0], in_byte3[0]} << {k, 1'b0};
        dec.fact  = {6'd0, in_byte7[1], in_byte3[1]} << {k, 1'b0};
      end
    end
  end

  // pair memory: read on accept, write back from the update stage
  always_ff @(posedge clk) begin
    if (wr_en) mem[s1_r.row] <= new_row;
    if (in_fire) rd_raw_r <= mem[dec.row];
  end

  // decode stage register, read forwarding and row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      row_valid_r <= '0;
    end else begin
      if (in_fire) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (wr_en) row_valid_r[s1_r.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r       <= dec;
      fwd_hit_r  <= wr_en && (s1_r.row == dec.row);
      fwd_data_r <= new_row;
      row_ok_r   <= row_valid_r[dec.row];
    end
  end

  // update stage: merge the row
  assign mux_q   = mux_duty(s1_r.mux_x);
  assign bank_q0 = bank_duty(s1_r.duty0);
  assign bank_q1 = bank_duty(s1_r.duty1);
  assign wr_en   = s1_adv && (s1_r.kind == KIND_MUXCTL || s1_r.kind == KIND_BANK ||
                              s1_r.kind == KIND_NATIVE);

  always_comb begin
    old_row = fwd_hit_r ? fwd_data_r : (row_ok_r ? rd_raw_r : '0);
    new_row = old_row;
    cnt     = 2'd0;
    case (s1_r.kind)
      KIND_NATIVE: begin
        new_row.freq0 = {2'b00, s1_r.freq0};
        new_row.duty0 = s1_r.duty0;
        new_row.freq1 = {2'b00, s1_r.freq1};
        new_row.duty1 = s1_r.duty1;
        cnt           = 2'd2;
      end
      KIND_BANK: begin
        new_row.duty0 = bank_q0;
        new_row.duty1 = bank_q1;
        if (old_row.freq0 == 16'd0) new_row.freq0 = BANK_FREQ;
        if (old_row.freq1 == 16'd0) new_row.freq1 = BANK_FREQ;
        cnt           = 2'd2;
      end
      KIND_MUXCTL: begin
        if (s1_r.half) begin
          new_row.duty1 = mux_q;
          new_row.freq1 = {2'b00, s1_r.freq0};
        end else begin
          new_row.duty0 = mux_q;
          new_row.freq0 = {2'b00, s1_r.freq0};
        end
        cnt = 2'd1;
      end
      default: ;
    endcase
  end

  // mask update
  assign safe_nxt = (safe_r & ~s1_r.fmask) | (s1_r.fsafe & s1_r.fmask);
  assign act_nxt  = (act_r & ~s1_r.fmask) | (s1_r.fact & s1_r.fmask);
  assign pull_nxt = (s1_r.kind == KIND_PULLUP) ? s1_r.pull : pull_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_r      <= '0;
      act_r       <= '0;
      pull_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        safe_r      <= safe_nxt;
        act_r       <= act_nxt;
        pull_r      <= pull_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      acc_r         <= (s1_r.kind != KIND_NONE);
      cnt_r         <= cnt;
      mchg_r        <= (safe_nxt != safe_r) || (act_nxt != act_r);
      pchg_r        <= (pull_nxt != pull_r);
      safe_o_r      <= safe_nxt;
      act_o_r       <= act_nxt;
      pull_o_r      <= pull_nxt;
      first_ch_r    <= (cnt != 2'd0) ? {s1_r.row, s1_r.half} : 3'd0;
      if (cnt == 2'd2) begin
        first_duty_r  <= new_row.duty0;
        first_freq_r  <= new_row.freq0;
        second_duty_r <= new_row.duty1;
        second_freq_r <= new_row.freq1;
      end else if (cnt == 2'd1) begin
        first_duty_r  <= s1_r.half ? new_row.duty1 : new_row.duty0;
        first_freq_r  <= s1_r.half ? new_row.freq1 : new_row.freq0;
        second_duty_r <= 8'd0;
        second_freq_r <= 16'd0;
      end else begin
        first_duty_r  <= 8'd0;
        first_freq_r  <= 16'd0;
        second_duty_r <= 8'd0;
        second_freq_r <= 16'd0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = acc_r;
  assign out_update_count   = cnt_r;
  assign out_mask_changed   = mchg_r;
  assign out_pullup_changed = pchg_r;
  assign out_safe_mask      = safe_o_r;
  assign out_active_mask    = act_o_r;
  assign out_pullup_mask    = pull_o_r;
  assign out_first_channel  = first_ch_r;
  assign out_first_duty     = first_duty_r;
  assign out_first_freq     = first_freq_r;
  assign out_second_duty    = second_duty_r;
  assign out_second_freq    = second_freq_r;

endmodule

`default_nettype wire

[rtl/cocd_checker.sv]
// ----------------------------------------------------------------------------
// cocd_checker
// port-level checks on the result channel of the decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cocd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_accepted,
  input wire logic [1:0]  out_update_count,
  input wire logic        out_mask_changed,
  input wire logic        out_pullup_changed,
  input wire logic [2:0]  out_first_channel,
  input wire logic [7:0]  out_first_duty,
  input wire logic [15:0] out_first_freq,
  input wire logic [7:0]  out_second_duty,
  input wire logic [15:0] out_second_freq
);

  // no beat offered right after reset
  `ASSERT_ALWAYS(a_no_beat_after_reset, !rst_n |=> !out_valid, "out_valid after reset")

  // a stalled beat stays offered
  `ASSERT_ON_CLK(a_hold_valid, out_valid && !out_ready |=> out_valid, "out_valid dropped")

  // a rejected frame reports no update and no change
  `ASSERT_ON_CLK(a_reject_quiet,
    out_valid && !out_accepted |-> out_update_count == 2'd0 && !out_mask_changed &&
    !out_pullup_changed, "rejected frame reports activity")

  // no channel fields without a channel update, no second without a pair
  `ASSERT_ON_CLK(a_idle_fields,
    out_valid && out_update_count != 2'd2 |-> out_second_duty == 8'd0 &&
    out_second_freq == 16'd0 && (out_update_count != 2'd0 || (out_first_channel == 3'd0 &&
    out_first_duty == 8'd0 && out_first_freq == 16'd0)), "stray channel fields")

  // a pair update starts on an even channel
  `ASSERT_ON_CLK(a_pair_even,
    out_valid && out_update_count == 2'd2 |-> !out_first_channel[0] && out_accepted,
    "pair update not even aligned")

endmodule

bind can_output_command_decoder cocd_checker u_cocd_checker (.*);

`default_nettype wire

[tb/sv/can_output_command_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_output_command_decoder_test
// Self-checking bench for the CAN output command decoder. A short directed
// table walks the edge cases of the native, mux and bank layouts, then ten
// randomly configured phases send mostly well-formed frames with some noise.
// Every result beat is compared with a table entry or a local prediction.
// ----------------------------------------------------------------------------

module can_output_command_decoder_test;
  import cocd_pkg::*;

  localparam logic [3:0] MODE_NATIVE     = 4'd0;
  localparam logic [3:0] MODE_NATIVE_TOP = 4'd15;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_FRAMES  = 100;
  localparam int HOLD_AFTER    = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int REPORT_MAX    = 10;

  // one received frame, data[i] is byte i
  typedef struct packed {
    logic [10:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] data;
  } frame_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  update_count;
    logic        mask_changed;
    logic        pullup_changed;
    logic [7:0]  safe_mask;
    logic [7:0]  active_mask;
    logic [7:0]  pullup_mask;
    logic [2:0]  first_channel;
    logic [7:0]  first_duty;
    logic [15:0] first_freq;
    logic [7:0]  second_duty;
    logic [15:0] second_freq;
  } result_t;

  // directed table row: either a register setting or a frame
  typedef struct {
    bit          is_cfg;
    bit          has_want;
    frame_t      fr;
    result_t     want;
    logic [3:0]  mode;
    logic [10:0] base;
    logic [13:0] dflt;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [10:0] in_frame_id;
  logic [3:0]  in_frame_length;
  logic [7:0]  in_byte0, in_byte1, in_byte2, in_byte3;
  logic [7:0]  in_byte4, in_byte5, in_byte6, in_byte7;
  logic        out_valid;
  logic        out_ready;
  logic        out_accepted;
  logic [1:0]  out_update_count;
  logic        out_mask_changed;
  logic        out_pullup_changed;
  logic [7:0]  out_safe_mask;
  logic [7:0]  out_active_mask;
  logic [7:0]  out_pullup_mask;
  logic [2:0]  out_first_channel;
  logic [7:0]  out_first_duty;
  logic [15:0] out_first_freq;
  logic [7:0]  out_second_duty;
  logic [15:0] out_second_freq;

  // predicted decoder state and register copy
  logic [15:0] chan_freq [CHANNELS];
  logic [7:0]  chan_duty [CHANNELS];
  logic [7:0]  safe_bits;
  logic [7:0]  active_bits;
  logic [7:0]  pullup_bits;
  logic [3:0]  cur_mode;
  logic [10:0] cur_base;
  logic [13:0] cur_dflt;

  result_t   pending_results[$];
  step_row_t directed_steps[$];
  int        fail_count   = 0;
  int        results_seen = 0;
  int        cycle_count  = 0;
  int        burst_left   = 0;

  can_output_command_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_frame_id        (in_frame_id),
    .in_frame_length    (in_frame_length),
    .in_byte0           (in_byte0),
    .in_byte1           (in_byte1),
    .in_byte2           (in_byte2),
    .in_byte3           (in_byte3),
    .in_byte4           (in_byte4),
    .in_byte5           (in_byte5),
    .in_byte6           (in_byte6),
    .in_byte7           (in_byte7),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_update_count   (out_update_count),
    .out_mask_changed   (out_mask_changed),
    .out_pullup_changed (out_pullup_changed),
    .out_safe_mask      (out_safe_mask),
    .out_active_mask    (out_active_mask),
    .out_pullup_mask    (out_pullup_mask),
    .out_first_channel  (out_first_channel),
    .out_first_duty     (out_first_duty),
    .out_first_freq     (out_first_freq),
    .out_second_duty    (out_second_duty),
    .out_second_freq    (out_second_freq)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void set_channel_flags(input int unsigned ch, input bit safe_on,
                                            input bit act_high);
    safe_bits[ch]   = safe_on;
    active_bits[ch] = act_high;
  endfunction

  // apply one frame to the predicted state and build the expected result
  function automatic result_t decode_frame(input frame_t fr);
    result_t     r;
    logic [7:0]  safe_was, active_was, pull_was;
    int unsigned id, base, ch, first, start, shift;
    int unsigned duty_in, period, hz, raw, fl, f, o;
    bit          mux_ok, hit;
    r          = '0;
    safe_was   = safe_bits;
    active_was = active_bits;
    pull_was   = pullup_bits;
    first      = 0;
    id         = fr.id;
    base       = cur_base;
    case (cur_mode)
      MODE_MUX_A, MODE_MUX_B: begin
        start  = (cur_mode == MODE_MUX_B) ? 4 : 0;
        mux_ok = (fr.data[0][7:5] == MUX_TAG) && (fr.data[0][3:0] < 4'd4);
        ch     = start + fr.data[0][1:0];
        if (fr.id == ID_MUX_CTL && fr.len >= 4'd5 && mux_ok) begin
          duty_in = {fr.data[1], fr.data[2]};
          period  = {fr.data[3], fr.data[4]};
          if (duty_in > MUX_DUTY_MAX) duty_in = MUX_DUTY_MAX;
          if (period == 0) hz = cur_dflt;
          else hz = (period / 4 == 0) ? 1 : period / 4;
          chan_duty[ch] = 8'((duty_in * 255 + 500) / 1000);
          chan_freq[ch] = 16'(hz);
          r.accepted     = 1'b1;
          r.update_count = 2'd1;
          first          = ch;
        end else if (fr.id == ID_MUX_CFG && fr.len >= 4'd2 && mux_ok) begin
          set_channel_flags(ch, fr.data[1][2:1] == 2'd1 || fr.data[1][2:1] == 2'd2,
                            fr.data[1][0]);
          r.accepted = 1'b1;
        end
      end
      MODE_BANK_A, MODE_BANK_B, MODE_BANK_AB: begin
        shift = (cur_mode == MODE_BANK_B) ? 1 : 0;
        start = 0;
        hit   = 1'b1;
        if (id == ID_BANK_LO + shift) start = 0;
        else if (id == ID_BANK_HI + shift) start = 2;
        else if (cur_mode == MODE_BANK_AB && id == ID_BANK_LO + 1) start = 4;
        else if (cur_mode == MODE_BANK_AB && id == ID_BANK_HI + 1) start = 6;
        else hit = 1'b0;
        if (hit && fr.len >= 4'd6) begin
          for (int i = 0; i < 2; i++) begin
            ch  = start + i;
            raw = fr.data[4 * i];
            fl  = fr.data[1 + 4 * i];
            if (raw == 0) chan_duty[ch] = 8'd0;
            else if (raw >= BANK_RAW_SAT) chan_duty[ch] = 8'd255;
            else chan_duty[ch] = 8'((raw * 255 + 124) / 249);
            set_channel_flags(ch, (fl & BANK_SAFE) != 0, (fl & BANK_ACTLOW) == 0);
            if (chan_freq[ch] == 16'd0) chan_freq[ch] = BANK_FREQ;
          end
          r.accepted     = 1'b1;
          r.update_count = 2'd2;
          first          = start;
        end
      end
      default: begin
        // native window, compared without wrapping the identifier
        if (id == base + 4) begin
          if (fr.len >= 4'd1) begin
            pullup_bits = fr.data[0];
            r.accepted  = 1'b1;
          end
        end else if (id >= base && id <= base + 3 && fr.len >= 4'd8) begin
          first = (id - base) * 2;
          for (int i = 0; i < 2; i++) begin
            o  = 4 * i;
            ch = first + i;
            f  = {fr.data[o + 1], fr.data[o]};
            if (f == 0) f = cur_dflt;
            if (f < FREQ_MIN) f = FREQ_MIN;
            if (f > FREQ_MAX) f = FREQ_MAX;
            chan_freq[ch] = 16'(f);
            chan_duty[ch] = fr.data[o + 2];
            set_channel_flags(ch, fr.data[o + 3][0], fr.data[o + 3][1]);
          end
          r.accepted     = 1'b1;
          r.update_count = 2'd2;
        end
      end
    endcase
    r.mask_changed   = (safe_bits != safe_was) || (active_bits != active_was);
    r.pullup_changed = (pullup_bits != pull_was);
    r.safe_mask      = safe_bits;
    r.active_mask    = active_bits;
    r.pullup_mask    = pullup_bits;
    if (r.update_count >= 2'd1) begin
      r.first_channel = 3'(first);
      r.first_duty    = chan_duty[first];
      r.first_freq    = chan_freq[first];
      if (r.update_count >= 2'd2 && first + 1 < CHANNELS) begin
        r.second_duty = chan_duty[first + 1];
        r.second_freq = chan_freq[first + 1];
      end
    end
    return r;
  endfunction

  // mostly well-formed frames for the current layout, some corrupted
  function automatic frame_t random_frame();
    frame_t      fr;
    int unsigned k, pick;
    logic [15:0] word;
    for (int i = 0; i < 8; i++) fr.data[i] = 8'($urandom);
    fr.id  = 11'($urandom);
    fr.len = 4'($urandom);
    case (cur_mode)
      MODE_MUX_A, MODE_MUX_B: begin
        fr.data[0] = {MUX_TAG, 1'($urandom), 2'b00, 2'($urandom)};
        if ($urandom_range(0, 4) < 3) begin
          fr.id  = ID_MUX_CTL;
          fr.len = 4'($urandom_range(5, 15));
          case ($urandom_range(0, 3))
            0: word = 16'd0;
            1: word = 16'(MUX_DUTY_MAX);
            2: word = 16'($urandom_range(1001, 65535));
            default: word = 16'($urandom_range(0, 1000));
          endcase
          fr.data[1] = word[15:8];
          fr.data[2] = word[7:0];
          case ($urandom_range(0, 3))
            0: word = 16'd0;
            1: word = 16'($urandom_range(1, 7));
            default: word = 16'($urandom);
          endcase
          fr.data[3] = word[15:8];
          fr.data[4] = word[7:0];
        end else begin
          fr.id  = ID_MUX_CFG;
          fr.len = 4'($urandom_range(2, 15));
        end
      end
      MODE_BANK_A, MODE_BANK_B, MODE_BANK_AB: begin
        pick   = $urandom_range(0, 3);
        fr.id  = 11'((pick[0] ? ID_BANK_HI : ID_BANK_LO) +
                     ((cur_mode == MODE_BANK_B || (cur_mode == MODE_BANK_AB && pick[1])) ?
                      1 : 0));
        fr.len = 4'($urandom_range(6, 15));
        for (int i = 0; i < 2; i++) begin
          case ($urandom_range(0, 3))
            0: fr.data[4 * i] = 8'd0;
            1: fr.data[4 * i] = 8'($urandom_range(1, 3));
            2: fr.data[4 * i] = 8'($urandom_range(245, 255));
            default: fr.data[4 * i] = 8'($urandom);
          endcase
        end
      end
      default: begin
        k      = ($urandom_range(0, 5) == 0) ? 4 : $urandom_range(0, 3);
        fr.id  = 11'(cur_base + k);
        if (k == 4) fr.len = 4'($urandom_range(1, 15));
        else fr.len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
        for (int i = 0; i < 2; i++) begin
          case ($urandom_range(0, 3))
            0: word = 16'd0;
            1: word = 16'($urandom_range(1, 60));
            2: word = 16'($urandom_range(9990, 10010));
            default: word = 16'($urandom);
          endcase
          fr.data[4 * i]     = word[7:0];
          fr.data[4 * i + 1] = word[15:8];
        end
      end
    endcase
    // noise and broken frames
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0: fr.id = 11'($urandom);
        1: fr.len = 4'($urandom_range(0, 7));
        2: fr.data[0] = 8'($urandom);
        default: begin
          fr.id  = 11'($urandom);
          fr.len = 4'($urandom);
        end
      endcase
    end
    return fr;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf({"acc=%0d cnt=%0d mchg=%0d pchg=%0d safe=%02h act=%02h pull=%02h ",
                      "ch=%0d d0=%02h f0=%0d d1=%02h f1=%0d"},
                     r.accepted, r.update_count, r.mask_changed, r.pullup_changed,
                     r.safe_mask, r.active_mask, r.pullup_mask, r.first_channel,
                     r.first_duty, r.first_freq, r.second_duty, r.second_freq);
  endfunction

  // data holds byte0 in its top byte
  function automatic void add_frame(input logic [10:0] id, input logic [3:0] len,
                                    input logic [63:0] data, input bit has_want = 1'b0,
                                    input result_t want = '0);
    step_row_t row;
    row          = '{default: '0};
    row.fr.id    = id;
    row.fr.len   = len;
    for (int i = 0; i < 8; i++) row.fr.data[i] = data[63 - 8 * i -: 8];
    row.has_want = has_want;
    row.want     = want;
    directed_steps.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [3:0] mode, input logic [10:0] base,
                                  input logic [13:0] dflt);
    step_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.mode   = mode;
    row.base   = base;
    row.dflt   = dflt;
    directed_steps.push_back(row);
  endfunction

  // drop valid and wait until every result beat is back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] mode, input logic [10:0] base,
                            input logic [13:0] dflt);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= 14'(mode);
    @(negedge clk);
    cfg_index <= REG_BASE;
    cfg_data  <= 14'(base);
    @(negedge clk);
    cfg_index <= REG_DFLT;
    cfg_data  <= dflt;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_mode = mode;
    cur_base = base;
    cur_dflt = dflt;
  endtask

  // offer one frame beat, in bursts with random gaps
  task automatic send_frame(input frame_t fr, input bit has_want, input result_t want);
    int      gap_len;
    result_t predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap_len    = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 25) : 0;
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_frame_id     <= fr.id;
    in_frame_length <= fr.len;
    in_byte0        <= fr.data[0];
    in_byte1        <= fr.data[1];
    in_byte2        <= fr.data[2];
    in_byte3        <= fr.data[3];
    in_byte4        <= fr.data[4];
    in_byte5        <= fr.data[5];
    in_byte6        <= fr.data[6];
    in_byte7        <= fr.data[7];
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = decode_frame(fr);
    pending_results.push_back(has_want ? want : predicted);
  endtask

  // result receiver: own stall pattern plus one long hold-off
  initial begin
    int  go_left, stall_left, hold_left;
    bit  hold_done;
    go_left    = 0;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (go_left != 0) begin
        go_left--;
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        go_left    = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                     $urandom_range(1, 8);
        stall_left = $urandom_range(0, 4);
        out_ready  <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    result_t got, want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        got = '{accepted: out_accepted, update_count: out_update_count,
                mask_changed: out_mask_changed, pullup_changed: out_pullup_changed,
                safe_mask: out_safe_mask, active_mask: out_active_mask,
                pullup_mask: out_pullup_mask, first_channel: out_first_channel,
                first_duty: out_first_duty, first_freq: out_first_freq,
                second_duty: out_second_duty, second_freq: out_second_freq};
        results_seen++;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) $display("unexpected result beat: %s", fmt_result(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("mismatch at beat %0d", results_seen);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("can_output_command_decoder_test NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    logic [3:0]  mode;
    logic [10:0] base;
    logic [13:0] dflt;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_MODE;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_frame_id     = '0;
    in_frame_length = '0;
    in_byte0        = '0;
    in_byte1        = '0;
    in_byte2        = '0;
    in_byte3        = '0;
    in_byte4        = '0;
    in_byte5        = '0;
    in_byte6        = '0;
    in_byte7        = '0;
    out_ready       = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_freq[i] = '0;
      chan_duty[i] = '0;
    end
    safe_bits   = '0;
    active_bits = '0;
    pullup_bits = '0;
    cur_mode    = MODE_NATIVE;
    cur_base    = '0;
    cur_dflt    = DFLT_RESET;

    // reset register values: rejects, pull-up, then a full pair with extremes
    add_frame(11'h123, 4'd8, {8{8'hFF}}, 1'b1, '0);
    add_frame(11'h004, 4'd0, {8{8'hFF}}, 1'b1, '0);
    add_frame(11'h004, 4'd1, 64'hFF000000_00000000, 1'b1,
              '{accepted: 1'b1, pullup_changed: 1'b1, pullup_mask: 8'hFF, default: '0});
    add_frame(11'h000, 4'd8, 64'h0000FF03_FFFF0000, 1'b1,
              '{accepted: 1'b1, update_count: 2'd2, mask_changed: 1'b1,
                pullup_changed: 1'b0, safe_mask: 8'h01, active_mask: 8'h01,
                pullup_mask: 8'hFF, first_channel: 3'd0, first_duty: 8'hFF,
                first_freq: 16'd1000, second_duty: 8'h00, second_freq: 16'd10000});
    // length above eight, frequency clamps, short pair frame
    add_frame(11'h003, 4'd15, 64'h01008001_10277F02);
    add_frame(11'h001, 4'd7, 64'h11223344_55667788);
    // window at the top of the identifier range
    add_cfg(MODE_NATIVE, 11'd2047, 14'd50);
    add_frame(11'd2047, 4'd8, 64'h00001203_00003400);
    add_frame(11'd3, 4'd1, 64'hA5000000_00000000);
    add_cfg(MODE_NATIVE_TOP, 11'd2044, 14'd10000);
    add_frame(11'd2047, 4'd8, 64'h00005501_3200AA02);
    add_frame(11'd0, 4'd1, 64'h5A000000_00000000);
    // mux bank A: saturated duty, zero and tiny periods, bad tag and index
    add_cfg(MODE_MUX_A, 11'd0, 14'd10000);
    add_frame(ID_MUX_CTL, 4'd5, 64'h40FFFF00_00000000);
    add_frame(ID_MUX_CTL, 4'd8, 64'h53000000_03000000);
    add_frame(ID_MUX_CTL, 4'd5, 64'h4101F4FF_FF000000);
    add_frame(ID_MUX_CTL, 4'd5, 64'h2001F4FF_FF000000);
    add_frame(ID_MUX_CTL, 4'd5, 64'h4401F4FF_FF000000);
    add_frame(ID_MUX_CTL, 4'd4, 64'h4001F4FF_FF000000);
    add_frame(ID_MUX_CFG, 4'd2, 64'h42020000_00000000);
    add_frame(ID_MUX_CFG, 4'd2, 64'h43070000_00000000);
    // mux bank B
    add_cfg(MODE_MUX_B, 11'd0, 14'd1000);
    add_frame(ID_MUX_CTL, 4'd5, 64'h5203E801_00000000);
    add_frame(ID_MUX_CFG, 4'd1, 64'h42020000_00000000);
    // bank layouts: raw extremes, flag polarity, wrong identifier
    add_cfg(MODE_BANK_A, 11'd0, 14'd1000);
    add_frame(ID_BANK_LO, 4'd6, 64'h00300000_FF000000);
    add_frame(ID_BANK_HI, 4'd6, 64'hF9100000_01200000);
    add_frame(ID_BANK_LO + 11'd1, 4'd8, 64'h80000000_80000000);
    add_cfg(MODE_BANK_B, 11'd0, 14'd1000);
    add_frame(ID_BANK_LO + 11'd1, 4'd6, 64'h7C3F0000_FA100000);
    add_cfg(MODE_BANK_AB, 11'd0, 14'd1000);
    add_frame(ID_BANK_HI + 11'd1, 4'd6, 64'h02000000_F8300000);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        set_config(directed_steps[i].mode, directed_steps[i].base, directed_steps[i].dflt);
      end else begin
        send_frame(directed_steps[i].fr, directed_steps[i].has_want, directed_steps[i].want);
      end
    end

    // random phases, each with its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 6) mode = 4'(phase);
      else if (phase == 6) mode = MODE_NATIVE_TOP;
      else mode = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: base = 11'd0;
        1: base = 11'd2047;
        2: base = 11'($urandom_range(2040, 2047));
        default: base = 11'($urandom_range(0, 2047));
      endcase
      case ($urandom_range(0, 3))
        0: dflt = 14'(FREQ_MIN);
        1: dflt = 14'(FREQ_MAX);
        default: dflt = 14'($urandom_range(50, 10000));
      endcase
      set_config(mode, base, dflt);
      repeat (PHASE_FRAMES) send_frame(random_frame(), 1'b0, '0);
    end

    // drain
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("can_output_command_decoder_test OK");
    end else begin
      $display("can_output_command_decoder_test NOT OK");
    end
    $finish;
  end

endmodule
